// ===== sv/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared widths and types for the 4x4 accumulating multiply tile.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int Tile     = 4;
  localparam int DataW    = 16;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = 43;
  localparam int ColW     = 2;
  localparam int InDataW  = 2 * Tile * DataW;
  localparam int SumsW    = Tile * AccW;
  localparam int OutDataW = ((SumsW + 7) / 8) * 8;

  typedef logic signed [DataW-1:0] operand_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // One B column: the sums of A rows 0..3, row 0 in the low bits.
  typedef acc_t [Tile-1:0] acc_col_t;
  // A whole tile, indexed by B column.
  typedef acc_col_t [Tile-1:0] tile_t;

endpackage

// ===== sv/mtt_mac_array.sv =====
// ----------------------------------------------------------------------------
// mtt_mac_array
// Input register, sixteen multipliers with a product register, and the
// sixteen tile accumulators that are handed off and cleared on a last term.
// ----------------------------------------------------------------------------
module mtt_mac_array import mtt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_last_i,
  input  logic                buf_free_i,
  output logic                load_o,
  output tile_t               tile_o
);

  logic     s0_valid_r;
  operand_t s0_a_r [Tile];
  operand_t s0_b_r [Tile];
  logic     s0_last_r;

  logic     s1_valid_r;
  prod_t    s1_prod_r [Tile][Tile];
  logic     s1_last_r;

  tile_t    acc_r;
  tile_t    acc_nxt;
  tile_t    sums;
  prod_t    prod [Tile][Tile];

  logic     s0_adv;
  logic     s1_adv;
  logic     in_fire;

  // A last term waits in the product register until the output buffer can
  // take the finished tile; ordinary terms always drain.
  assign s1_adv     = s1_valid_r && (!s1_last_r || buf_free_i);
  assign s0_adv     = s0_valid_r && (!s1_valid_r || s1_adv);
  assign in_ready_o = !s0_valid_r || s0_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    for (int c = 0; c < Tile; c++) begin
      for (int r = 0; r < Tile; r++) begin
        prod[c][r] = s0_a_r[r] * s0_b_r[c];
        sums[c][r] = acc_r[c][r] +
                     {{(AccW-ProdW){s1_prod_r[c][r][ProdW-1]}}, s1_prod_r[c][r]};
      end
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s1_adv) begin
      acc_nxt = s1_last_r ? '0 : sums;
    end
  end

  assign load_o = s1_adv && s1_last_r;
  assign tile_o = sums;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_r <= 1'b0;
      end
      if (s0_adv) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int r = 0; r < Tile; r++) begin
        s0_a_r[r] <= in_data_i[r*DataW +: DataW];
        s0_b_r[r] <= in_data_i[(Tile+r)*DataW +: DataW];
      end
      s0_last_r <= in_last_i;
    end
    if (s0_adv) begin
      for (int c = 0; c < Tile; c++) begin
        for (int r = 0; r < Tile; r++) begin
          s1_prod_r[c][r] <= prod[c][r];
        end
      end
      s1_last_r <= s0_last_r;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_o |=> (acc_r == '0))
    else $error("accumulators not cleared after a last term");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !buf_free_i) |=> (s1_valid_r && s1_last_r && !load_o ||
                                                  s1_valid_r && s1_last_r))
    else $error("blocked last term lost from the product register");

  a_hold_acc_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(acc_r))
    else $error("accumulators changed without a term");
`endif

endmodule

// ===== sv/mtt_out_buf.sv =====
// ----------------------------------------------------------------------------
// mtt_out_buf
// Holds one finished tile and sends it out one B column per transfer.
// ----------------------------------------------------------------------------
module mtt_out_buf import mtt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  tile_t                tile_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutDataW-1:0]  out_data_o,
  output logic [ColW-1:0]      out_col_o,
  output logic                 out_last_o
);

  tile_t           buf_r;
  logic            busy_r;
  logic [ColW-1:0] col_r;
  logic            out_fire;
  logic            last_col;

  assign last_col    = (col_r == ColW'(Tile - 1));
  assign out_fire    = busy_r && out_ready_i;
  // The next tile may land on the same edge as the final column leaves.
  assign free_o      = !busy_r || (out_fire && last_col);
  assign out_valid_o = busy_r;
  assign out_data_o  = {{(OutDataW-SumsW){1'b0}}, buf_r[col_r]};
  assign out_col_o   = col_r;
  assign out_last_o  = last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else if (load_i) begin
      busy_r <= 1'b1;
      col_r  <= '0;
    end else if (out_fire) begin
      if (last_col) begin
        busy_r <= 1'b0;
        col_r  <= '0;
      end else begin
        col_r <= col_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      buf_r <= tile_i;
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> free_o)
    else $error("tile loaded over one still being sent");

  a_load_starts_col0: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |=> (busy_r && col_r == '0))
    else $error("new tile does not start at the first column");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && last_col && !load_i) |=> !busy_r)
    else $error("buffer still busy after its final column");
`endif

endmodule

// ===== sv/matmul_tile_4x4_accumulate.sv =====
// ----------------------------------------------------------------------------
// matmul_tile_4x4_accumulate
// 4x4 register-tiled multiply-accumulate kernel with streaming ports.
// ----------------------------------------------------------------------------
// Each input transfer carries element k of four A rows and four B columns;
// the block adds all sixteen 16x16 signed products into sixteen 43-bit
// accumulators and takes one input transfer per cycle unless a last term
// waits for the output buffer. The path is an input register, a product
// register and the accumulators, in that order. On a transfer with in_tlast set
// the finished tile moves into an output buffer and the accumulators clear;
// the buffer sends four results, B columns 0 to 3, one per cycle while
// out_tready is high, the last with out_tlast. Terms without in_tlast keep
// flowing while a tile drains; a further in_tlast term waits in the product
// register until the buffer sends its final column, and the input stalls
// behind it, which holds back very short tiles.
module matmul_tile_4x4_accumulate import mtt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // a_elem_0, a_elem_1, a_elem_2, a_elem_3, b_elem_0, b_elem_1, b_elem_2,
  // b_elem_3, 16 bits each, from bit 0 up.
  input  logic [InDataW-1:0]   in_tdata,
  input  logic                 in_tlast,   // last_term
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sum_0, sum_1, sum_2, sum_3, 43 bits each, from bit 0 up; zero padded.
  output logic [OutDataW-1:0]  out_tdata,
  output logic [ColW-1:0]      out_tuser,  // column_index
  output logic                 out_tlast   // last_out
);

  logic  buf_free;
  logic  load;
  tile_t tile;

  mtt_mac_array u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .in_data_i  (in_tdata),
    .in_last_i  (in_tlast),
    .buf_free_i (buf_free),
    .load_o     (load),
    .tile_o     (tile)
  );

  mtt_out_buf u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .tile_i      (tile),
    .free_o      (buf_free),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_tdata),
    .out_col_o   (out_tuser),
    .out_last_o  (out_tlast)
  );

endmodule

// ===== sim/matmul_tile_4x4_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// matmul_tile_4x4_accumulate_tb
// Self-checking testbench for the 4x4 accumulating multiply tile.
// ----------------------------------------------------------------------------
// Terms are streamed into the block with random gaps while the result side
// stalls at random. A scoreboard keeps its own sixteen 43-bit sums, adds
// every accepted term, and on each term marked last queues the four column
// results it expects. Every result transfer is checked field by field
// against the oldest queued column. Directed tests cover operand extremes,
// lane ordering, multi-term runs and single-term tiles; random tiles and one
// long output hold-off follow.
// ----------------------------------------------------------------------------
module matmul_tile_4x4_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtt_pkg::*;

  typedef operand_t [Tile-1:0] lane_t;

  typedef struct {
    acc_col_t            sums;
    logic [ColW-1:0]     col;
    logic                last;
  } column_result_t;

  localparam operand_t OperandMin  = operand_t'(1 << (DataW - 1));
  localparam operand_t OperandMax  = operand_t'((1 << (DataW - 1)) - 1);
  localparam int       IdleLimit   = 2000;
  localparam int       HoldCycles  = 300;
  localparam int       DrainCycles = 16;
  localparam int       ItemTarget  = 65;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // a_elem_0..a_elem_3, b_elem_0..b_elem_3, 16 bits each, from bit 0 up.
  logic [InDataW-1:0]  in_tdata;
  logic                in_tlast;   // last_term
  logic                out_tvalid;
  logic                out_tready;
  // sum_0..sum_3, 43 bits each, from bit 0 up; zero padded.
  logic [OutDataW-1:0] out_tdata;
  logic [ColW-1:0]     out_tuser;  // column_index
  logic                out_tlast;  // last_out

  tile_t               tile_sums;
  column_result_t      pending_columns[$];
  int                  mismatch_count;
  int                  idle_cycles;
  int                  hold_cycles_req;
  logic                no_idle;

  matmul_tile_4x4_accumulate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic tile_t add_terms(input tile_t acc, input lane_t a, input lane_t b);
    prod_t p;
    for (int c = 0; c < Tile; c++) begin
      for (int r = 0; r < Tile; r++) begin
        p = $signed(a[r]) * $signed(b[c]);
        acc[c][r] = $signed(acc[c][r]) + $signed(p);
      end
    end
    return acc;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic lane_t splat(input operand_t v);
    lane_t l;
    for (int i = 0; i < Tile; i++) l[i] = v;
    return l;
  endfunction

  function automatic lane_t rand_lanes();
    lane_t l;
    for (int i = 0; i < Tile; i++) begin
      case ($urandom_range(0, 9))
        0: l[i] = OperandMin;
        1: l[i] = OperandMax;
        2: l[i] = '0;
        3: l[i] = '1;
        default: l[i] = operand_t'($urandom);
      endcase
    end
    return l;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_term(input lane_t a, input lane_t b, input logic last);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {b, a};
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // The hold-off request is picked up and counted down here, one cycle at a time.
  initial begin : result_ready
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 15) stall_left = stall_len();
      end
    end
  end

  // Outputs are checked before the same edge's input is folded in; a term
  // can never reach the output in the cycle it is accepted.
  always @(posedge clk) begin : scoreboard
    column_result_t  want;
    logic [AccW-1:0] got;
    logic            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pending_columns.size() == 0) begin
          $display("%0t: result transfer with none expected, column %0d", $time, out_tuser);
          mismatch_count++;
        end else begin
          want = pending_columns.pop_front();
          for (int r = 0; r < Tile; r++) begin
            got = out_tdata[r*AccW +: AccW];
            if (got !== want.sums[r]) begin
              $display("%0t: column %0d sum_%0d expected %0d, actual %0d",
                       $time, want.col, r, want.sums[r], $signed(got));
              mismatch_count++;
            end
          end
          if (out_tuser !== want.col) begin
            $display("%0t: column_index expected %0d, actual %0d", $time, want.col, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_out expected %0d, actual %0d", $time, want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        tile_sums = add_terms(tile_sums, in_tdata[Tile*DataW-1:0],
                              in_tdata[InDataW-1 -: Tile*DataW]);
        if (in_tlast) begin
          for (int c = 0; c < Tile; c++)
            pending_columns.push_back('{sums: tile_sums[c], col: ColW'(c),
                                        last: (c == Tile - 1)});
          tile_sums = '0;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_operand_extremes();
    send_term(splat(OperandMin), splat(OperandMin), 1'b1);
    send_term(splat(OperandMin), splat(OperandMax), 1'b1);
    send_term(splat(OperandMax), splat(OperandMax), 1'b1);
    send_term(splat('0), splat(OperandMin), 1'b1);
    send_term(splat('1), splat(OperandMin), 1'b1);
  endtask

  // Distinct values per lane expose any swap of rows, columns or result order.
  task automatic test_lane_mapping();
    lane_t a;
    lane_t b;
    for (int i = 0; i < Tile; i++) begin
      a[i] = operand_t'(i + 1);
      b[i] = operand_t'(1 << (4 * i));
    end
    send_term(a, b, 1'b0);
    for (int i = 0; i < Tile; i++) a[i] = operand_t'(-(i + 1) * 100);
    send_term(a, b, 1'b1);
  endtask

  task automatic test_multi_term_run();
    for (int k = 0; k < 7; k++) send_term(splat(OperandMin), splat(OperandMin), 1'b0);
    send_term(splat(OperandMax), splat(OperandMin), 1'b1);
  endtask

  task automatic test_back_to_back_tiles();
    no_idle = 1'b1;
    for (int k = 0; k < 5; k++) send_term(rand_lanes(), rand_lanes(), 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_tiles();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 40)      len = 1;
      else if (r < 80) len = $urandom_range(2, 6);
      else if (r < 95) len = $urandom_range(7, 20);
      else             len = $urandom_range(21, 60);
      no_idle = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len; k++) send_term(rand_lanes(), rand_lanes(), k == len - 1);
      sent += len;
    end
    no_idle = 1'b0;
  endtask

  // The result side holds off while short tiles keep coming, so the block
  // must fill up and push back on its input.
  task automatic test_output_backpressure();
    hold_cycles_req = HoldCycles;
    no_idle = 1'b1;
    for (int t = 0; t < 12; t++) begin
      send_term(rand_lanes(), rand_lanes(), 1'b0);
      send_term(rand_lanes(), rand_lanes(), 1'b1);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    no_idle         = 1'b0;
    hold_cycles_req = 0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    tile_sums       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_operand_extremes();
    test_lane_mapping();
    test_multi_term_run();
    test_back_to_back_tiles();
    test_random_tiles();
    test_output_backpressure();
    test_random_tiles();

    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
